FILE: hdl/tmfs_pkg.sv
// Package with the transaction types and fixed constants of the flow shop sequencer.
`timescale 1ns / 1ps

package tmfs_pkg;

    // Widths of the external payload fields.
    localparam int unsigned FIELD_TIME_BITS = 16;
    localparam int unsigned JOB_INDEX_BITS  = 6;

    // Default sizing of the sorter.
    localparam int unsigned DEF_MAX_JOBS  = 64;
    localparam int unsigned DEF_TIME_BITS = 16;

    // One job as it arrives.
    typedef struct packed {
        logic [FIELD_TIME_BITS-1:0] time_first;
        logic [FIELD_TIME_BITS-1:0] time_second;
        logic                       last_job;
    } job_t;

    // One position of the emitted sequence.
    typedef struct packed {
        logic [JOB_INDEX_BITS-1:0] job_index;
        logic                      last_in_sequence;
        logic                      overflow;
    } seq_t;

    // Control broadcast to every cell of the sorter chain.
    typedef struct packed {
        logic shift;
    } cell_ctl_t;

endpackage

FILE: hdl/tmfs_cell.sv
// One cell of the systolic insertion sorter: holds one job and passes the later one on.
`timescale 1ns / 1ps

module tmfs_cell #(
    parameter int unsigned TIME_BITS = tmfs_pkg::DEF_TIME_BITS,
    parameter int unsigned IDX_BITS  = tmfs_pkg::JOB_INDEX_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tmfs_pkg::cell_ctl_t   ctl,
    // Job moving in from the left neighbor.
    input  logic                  left_valid,
    input  logic [TIME_BITS-1:0]  left_tf,
    input  logic [TIME_BITS-1:0]  left_ts,
    input  logic [IDX_BITS-1:0]   left_idx,
    // Held job of the right neighbor, taken when the chain shifts out.
    input  logic                  right_valid,
    input  logic [TIME_BITS-1:0]  right_tf,
    input  logic [TIME_BITS-1:0]  right_ts,
    input  logic [IDX_BITS-1:0]   right_idx,
    // Job held by this cell.
    output logic                  held_valid,
    output logic [TIME_BITS-1:0]  held_tf,
    output logic [TIME_BITS-1:0]  held_ts,
    output logic [IDX_BITS-1:0]   held_idx,
    // Job passed on to the right neighbor.
    output logic                  move_valid,
    output logic [TIME_BITS-1:0]  move_tf,
    output logic [TIME_BITS-1:0]  move_ts,
    output logic [IDX_BITS-1:0]   move_idx
);

    logic                 held_valid_reg, held_valid_next;
    logic [TIME_BITS-1:0] held_tf_reg, held_tf_next;
    logic [TIME_BITS-1:0] held_ts_reg, held_ts_next;
    logic [IDX_BITS-1:0]  held_idx_reg, held_idx_next;
    logic                 move_valid_reg, move_valid_next;
    logic [TIME_BITS-1:0] move_tf_reg, move_tf_next;
    logic [TIME_BITS-1:0] move_ts_reg, move_ts_next;
    logic [IDX_BITS-1:0]  move_idx_reg, move_idx_next;

    logic left_in_a;
    logic held_in_a;
    logic left_first;

    // Johnson's rule: does the incoming job go before the held one?
    always_comb
    begin
        left_in_a = left_tf < left_ts;
        held_in_a = held_tf_reg < held_ts_reg;
        if (left_in_a != held_in_a)
        begin
            left_first = left_in_a;
        end
        else if (left_in_a)
        begin
            if (left_tf != held_tf_reg)
                left_first = left_tf < held_tf_reg;
            else
                left_first = left_idx < held_idx_reg;
        end
        else
        begin
            if (left_ts != held_ts_reg)
                left_first = left_ts > held_ts_reg;
            else if (left_tf != held_tf_reg)
                left_first = left_tf > held_tf_reg;
            else
                left_first = left_idx > held_idx_reg;
        end
    end

    // Insert, pass on, or shift toward the head of the chain.
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_tf_next    = held_tf_reg;
        held_ts_next    = held_ts_reg;
        held_idx_next   = held_idx_reg;
        move_valid_next = 1'b0;
        move_tf_next    = left_tf;
        move_ts_next    = left_ts;
        move_idx_next   = left_idx;
        if (ctl.shift)
        begin
            held_valid_next = right_valid;
            held_tf_next    = right_tf;
            held_ts_next    = right_ts;
            held_idx_next   = right_idx;
        end
        else if (left_valid)
        begin
            if (!held_valid_reg || left_first)
            begin
                held_valid_next = 1'b1;
                held_tf_next    = left_tf;
                held_ts_next    = left_ts;
                held_idx_next   = left_idx;
                // The displaced job, if any, travels on.
                move_valid_next = held_valid_reg;
                move_tf_next    = held_tf_reg;
                move_ts_next    = held_ts_reg;
                move_idx_next   = held_idx_reg;
            end
            else
            begin
                move_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            move_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            move_valid_reg <= move_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        held_tf_reg  <= held_tf_next;
        held_ts_reg  <= held_ts_next;
        held_idx_reg <= held_idx_next;
        move_tf_reg  <= move_tf_next;
        move_ts_reg  <= move_ts_next;
        move_idx_reg <= move_idx_next;
    end

    assign held_valid = held_valid_reg;
    assign held_tf    = held_tf_reg;
    assign held_ts    = held_ts_reg;
    assign held_idx   = held_idx_reg;
    assign move_valid = move_valid_reg;
    assign move_tf    = move_tf_reg;
    assign move_ts    = move_ts_reg;
    assign move_idx   = move_idx_reg;

endmodule

FILE: hdl/two_machine_flow_shop_sequencer.sv
// Top level of the two-machine flow shop sequencer (Johnson's rule).
//
// Jobs enter on the job channel (valid/ready), one transaction per job, and are
// numbered in arrival order. A job with last_job set closes the set; the whole set
// then leaves on the seq channel as a run of job indices in Johnson's order, with
// last_in_sequence on the final one and overflow on all of them if jobs beyond
// MAX_JOBS were dropped. The set is then empty again.
// Jobs are sorted as they arrive by a chain of MAX_JOBS cells; a job moves one cell
// per cycle until it settles. A new job can be loaded while earlier ones still
// travel the chain. After the last job, the sequencer waits in a settle state until
// the chain has settled, then the stored results leave at one per cycle while
// the receiver is ready. The job channel is held off while a set settles and
// drains; the last result may still wait in the output register while the next
// set loads. If the receiver stalls, the output register holds its transaction
// and the chain waits. Reset empties the chain and the output register and starts
// a new set.
`timescale 1ns / 1ps

module two_machine_flow_shop_sequencer #(
    parameter int unsigned MAX_JOBS  = tmfs_pkg::DEF_MAX_JOBS,
    parameter int unsigned TIME_BITS = tmfs_pkg::DEF_TIME_BITS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  tmfs_pkg::job_t job,
    output logic           seq_valid,
    input  logic           seq_ready,
    output tmfs_pkg::seq_t seq
);

    localparam int unsigned IDX_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int unsigned CNT_BITS = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [CNT_BITS-1:0]   job_count_reg;
    logic [CNT_BITS-1:0]   settle_reg;
    logic                  dropped_reg;
    logic                  inj_valid_reg;
    logic [TIME_BITS-1:0]  inj_tf_reg;
    logic [TIME_BITS-1:0]  inj_ts_reg;
    logic [IDX_BITS-1:0]   inj_idx_reg;
    logic                  seq_valid_reg;
    tmfs_pkg::seq_t        seq_reg;

    logic                  job_accept;
    logic                  has_room;
    logic [CNT_BITS-1:0]   job_count_next;
    logic                  load_out;
    tmfs_pkg::cell_ctl_t   cell_ctl;

    // Chain links: entry 0 is the injected job, entry MAX_JOBS is past the end.
    logic [MAX_JOBS:0]     mv_valid;
    logic [TIME_BITS-1:0]  mv_tf  [0:MAX_JOBS];
    logic [TIME_BITS-1:0]  mv_ts  [0:MAX_JOBS];
    logic [IDX_BITS-1:0]   mv_idx [0:MAX_JOBS];
    logic [MAX_JOBS:0]     hd_valid;
    logic [TIME_BITS-1:0]  hd_tf  [0:MAX_JOBS];
    logic [TIME_BITS-1:0]  hd_ts  [0:MAX_JOBS];
    logic [IDX_BITS-1:0]   hd_idx [0:MAX_JOBS];

    // Handshake and bookkeeping terms.
    assign job_ready      = (state_reg == ST_LOAD);
    assign job_accept     = job_valid && job_ready;
    assign has_room       = job_count_reg < CNT_BITS'(MAX_JOBS);
    assign job_count_next = has_room ? job_count_reg + CNT_BITS'(1) : job_count_reg;
    assign load_out       = (state_reg == ST_EMIT) && (!seq_valid_reg || seq_ready);
    assign cell_ctl.shift = load_out;

    // Head and tail of the chain.
    assign mv_valid[0]        = inj_valid_reg;
    assign mv_tf[0]           = inj_tf_reg;
    assign mv_ts[0]           = inj_ts_reg;
    assign mv_idx[0]          = inj_idx_reg;
    assign hd_valid[MAX_JOBS] = 1'b0;
    assign hd_tf[MAX_JOBS]    = '0;
    assign hd_ts[MAX_JOBS]    = '0;
    assign hd_idx[MAX_JOBS]   = '0;

    // Row of sorter cells.
    for (genvar gi = 0; gi < MAX_JOBS; gi++)
    begin : g_cell
        tmfs_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_BITS  (IDX_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .left_valid  (mv_valid[gi]),
            .left_tf     (mv_tf[gi]),
            .left_ts     (mv_ts[gi]),
            .left_idx    (mv_idx[gi]),
            .right_valid (hd_valid[gi+1]),
            .right_tf    (hd_tf[gi+1]),
            .right_ts    (hd_ts[gi+1]),
            .right_idx   (hd_idx[gi+1]),
            .held_valid  (hd_valid[gi]),
            .held_tf     (hd_tf[gi]),
            .held_ts     (hd_ts[gi]),
            .held_idx    (hd_idx[gi]),
            .move_valid  (mv_valid[gi+1]),
            .move_tf     (mv_tf[gi+1]),
            .move_ts     (mv_ts[gi+1]),
            .move_idx    (mv_idx[gi+1])
        );
    end

    // Sequencer state, counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            job_count_reg <= '0;
            settle_reg    <= '0;
            dropped_reg   <= 1'b0;
            inj_valid_reg <= 1'b0;
            seq_valid_reg <= 1'b0;
        end
        else
        begin
            inj_valid_reg <= 1'b0;
            if (seq_valid_reg && seq_ready)
                seq_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (job_accept)
                    begin
                        inj_valid_reg <= has_room;
                        job_count_reg <= job_count_next;
                        if (!has_room)
                            dropped_reg <= 1'b1;
                        if (job.last_job)
                        begin
                            settle_reg <= job_count_next;
                            state_reg  <= ST_SETTLE;
                        end
                    end
                end
                ST_SETTLE:
                begin
                    // The settle counter runs down until the last injected job has landed.
                    settle_reg <= settle_reg - CNT_BITS'(1);
                    if (settle_reg <= CNT_BITS'(1))
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (load_out)
                    begin
                        seq_valid_reg <= 1'b1;
                        job_count_reg <= job_count_reg - CNT_BITS'(1);
                        if (job_count_reg == CNT_BITS'(1))
                        begin
                            dropped_reg <= 1'b0;
                            state_reg   <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (job_accept)
        begin
            inj_tf_reg  <= TIME_BITS'(job.time_first);
            inj_ts_reg  <= TIME_BITS'(job.time_second);
            inj_idx_reg <= job_count_reg[IDX_BITS-1:0];
        end
        if (load_out)
        begin
            seq_reg.job_index        <= tmfs_pkg::JOB_INDEX_BITS'(hd_idx[0]);
            seq_reg.last_in_sequence <= (job_count_reg == CNT_BITS'(1));
            seq_reg.overflow         <= dropped_reg;
        end
    end

    assign seq_valid = seq_valid_reg;
    assign seq       = seq_reg;

    // The head cell holds a job whenever a result is taken from it.
    a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> hd_valid[0])
        else $error("sorter head empty while emitting");

    // A job is injected only after a stored transaction on the job channel.
    a_inj_origin : assert property (@(posedge clk) disable iff (!rst_n)
        inj_valid_reg |-> $past(job_accept))
        else $error("job injected without a transaction");

    // The job count never exceeds the chain length.
    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        job_count_reg <= CNT_BITS'(MAX_JOBS))
        else $error("job count beyond capacity");

    // Taking the final result reopens the job channel with an empty set.
    a_set_close : assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && job_count_reg == CNT_BITS'(1))
            |=> (state_reg == ST_LOAD && job_count_reg == '0 && !dropped_reg))
        else $error("set not closed after final result");

endmodule
